@@ hw/rtl/pqt_pkg.sv @@
// ----------------------------------------------------------------------------
// Pending query table package
// Field widths, request and status codes, and the command and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package pqt_pkg;

  localparam int ID_W       = 16;
  localparam int IP_W       = 32;
  localparam int PORT_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int SLOT_IDX_W = 6;

  // Request kinds
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the request
    logic match;     // register the per-slot match vector
    logic pick;      // register the lowest matching slot
    logic commit;    // update the slot, issue the RAM access
    logic load_out;  // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;       // some slot matched in the registered vector
  } sts_t;

endpackage

@@ hw/rtl/pqt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pqt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ hw/rtl/pqt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Pending query table controller
// Steps each request through match, pick, commit (on a hit only) and
// finish, and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module pqt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  pqt_pkg::sts_t sts,
  output pqt_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_PICK,
    S_COMMIT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Decode commands from the state
  always_comb begin
    cmd          = '0;
    cmd.capture  = in_valid && (state_r == S_IDLE);
    cmd.match    = (state_r == S_MATCH);
    cmd.pick     = (state_r == S_PICK);
    cmd.commit   = (state_r == S_COMMIT);
    cmd.load_out = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_MATCH;
      S_MATCH:  state_nxt = S_PICK;
      S_PICK:   state_nxt = sts.hit ? S_COMMIT : S_FINISH;
      S_COMMIT: state_nxt = S_FINISH;
      S_FINISH: if (cmd.load_out) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Hold the result valid until its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Never overwrite a result that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // A miss or full table never reaches the commit step
  a_commit_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) && !sts.hit |=> (state_r == S_FINISH))
    else $error("commit without a matching slot");

  // A new request is taken only after the previous one finished
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_MATCH) && !in_ready)
    else $error("request taken while busy");

endmodule

@@ hw/rtl/pqt_dp.sv @@
// ----------------------------------------------------------------------------
// Pending query table datapath
// Slot valid bits and identifiers in flops with a per-slot compare, a
// priority pick of the lowest matching slot, and a RAM for address and port.
// ----------------------------------------------------------------------------
module pqt_dp #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pqt_pkg::cmd_t                        cmd,
  output pqt_pkg::sts_t                        sts,
  input  logic                                 in_req_type,
  input  logic [pqt_pkg::ID_W-1:0]             in_query_id,
  input  logic [pqt_pkg::IP_W-1:0]             in_requester_ip,
  input  logic [pqt_pkg::PORT_W-1:0]           in_requester_port,
  output logic [pqt_pkg::STATUS_W-1:0]         out_status,
  output logic [pqt_pkg::SLOT_IDX_W-1:0]       out_slot_index,
  output logic [pqt_pkg::IP_W-1:0]             out_found_ip,
  output logic [pqt_pkg::PORT_W-1:0]           out_found_port
);

  localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int DATA_W = pqt_pkg::IP_W + pqt_pkg::PORT_W;

  // Latched request
  pqt_pkg::req_t                 req_type_r;
  logic [pqt_pkg::ID_W-1:0]      req_id_r;
  logic [pqt_pkg::IP_W-1:0]      req_ip_r;
  logic [pqt_pkg::PORT_W-1:0]    req_port_r;

  // Slot state
  logic [TABLE_SLOTS-1:0]        valid_r;
  logic [pqt_pkg::ID_W-1:0]      slot_id_r [TABLE_SLOTS];

  logic [TABLE_SLOTS-1:0]        match_nxt, match_r;
  logic [IDX_W-1:0]              sel_nxt, sel_r;
  logic                          hit_nxt, hit_r;
  logic                          ram_we;
  logic [DATA_W-1:0]             ram_rdata;

  // Result register
  logic [pqt_pkg::STATUS_W-1:0]   status_r;
  logic [pqt_pkg::SLOT_IDX_W-1:0] slot_index_r;
  logic [pqt_pkg::IP_W-1:0]       found_ip_r;
  logic [pqt_pkg::PORT_W-1:0]     found_port_r;

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r <= pqt_pkg::req_t'(in_req_type);
      req_id_r   <= in_query_id;
      req_ip_r   <= in_requester_ip;
      req_port_r <= in_requester_port;
    end
  end

  // Compare every slot: free slots for an insert, live matches for a lookup
  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (req_type_r == pqt_pkg::REQ_LOOKUP) begin
        match_nxt[i] = valid_r[i] && (slot_id_r[i] == req_id_r);
      end else begin
        match_nxt[i] = !valid_r[i];
      end
    end
  end

  // Pick the lowest set bit of the registered match vector
  always_comb begin
    sel_nxt = '0;
    hit_nxt = 1'b0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        sel_nxt = IDX_W'(i);
        hit_nxt = 1'b1;
      end
    end
  end

  assign sts.hit = hit_nxt;

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      match_r <= match_nxt;
    end
    if (cmd.pick) begin
      sel_r <= sel_nxt;
      hit_r <= hit_nxt;
    end
  end

  // Commit: claim the slot on insert, release it on lookup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      valid_r[sel_r] <= (req_type_r == pqt_pkg::REQ_INSERT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && (req_type_r == pqt_pkg::REQ_INSERT)) begin
      slot_id_r[sel_r] <= req_id_r;
    end
  end

  assign ram_we = cmd.commit && (req_type_r == pqt_pkg::REQ_INSERT);

  pqt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sel_r),
    .wdata ({req_ip_r, req_port_r}),
    .raddr (sel_r),
    .rdata (ram_rdata)
  );

  // Load the result
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r     <= pqt_pkg::ST_DONE;
      slot_index_r <= '0;
      found_ip_r   <= '0;
      found_port_r <= '0;
      if (!hit_r) begin
        status_r <= (req_type_r == pqt_pkg::REQ_INSERT) ? pqt_pkg::ST_FULL
                                                        : pqt_pkg::ST_MISS;
      end else begin
        slot_index_r <= pqt_pkg::SLOT_IDX_W'(sel_r);
        if (req_type_r == pqt_pkg::REQ_LOOKUP) begin
          found_ip_r   <= ram_rdata[DATA_W-1:pqt_pkg::PORT_W];
          found_port_r <= ram_rdata[pqt_pkg::PORT_W-1:0];
        end
      end
    end
  end

  assign out_status     = status_r;
  assign out_slot_index = slot_index_r;
  assign out_found_ip   = found_ip_r;
  assign out_found_port = found_port_r;

  // An insert only ever claims a free slot
  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (req_type_r == pqt_pkg::REQ_INSERT) |-> !valid_r[sel_r])
    else $error("insert into a live slot");

  // A lookup releases a live slot with the wanted identifier
  a_lookup_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (req_type_r == pqt_pkg::REQ_LOOKUP)
      |-> valid_r[sel_r] && (slot_id_r[sel_r] == req_id_r))
    else $error("release of a non-matching slot");

  // The released slot is free afterwards
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (req_type_r == pqt_pkg::REQ_LOOKUP) |=> !valid_r[$past(sel_r)])
    else $error("slot still live after release");

endmodule

@@ hw/rtl/pending_query_id_table_core.sv @@
// ----------------------------------------------------------------------------
// Pending query identifier table
// Holds outstanding forwarded queries; inserts into the lowest free slot and
// releases the lowest live slot that matches a looked-up identifier.
//
//   Channel  Ports                                             Direction
//   in       in_valid/in_ready, in_req_type, in_query_id,      to block
//            in_requester_ip, in_requester_port
//   out      out_valid/out_ready, out_status, out_slot_index,  from block
//            out_found_ip, out_found_port
//
// A request passes from its transfer through match compare, priority pick,
// slot update with the RAM access and result load; a miss or full table
// skips the slot update. One request is in flight at a time, so a new
// request is taken only once the previous one has loaded its result.
// Reset clears all slot valid bits together; no clearing pass.
// A stalled result holds in the output register; the next request is still
// taken and waits in the finish step until the register frees.
// ----------------------------------------------------------------------------
module pending_query_id_table_core #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [pqt_pkg::ID_W-1:0]       in_query_id,
  input  logic [pqt_pkg::IP_W-1:0]       in_requester_ip,
  input  logic [pqt_pkg::PORT_W-1:0]     in_requester_port,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pqt_pkg::STATUS_W-1:0]   out_status,
  output logic [pqt_pkg::SLOT_IDX_W-1:0] out_slot_index,
  output logic [pqt_pkg::IP_W-1:0]       out_found_ip,
  output logic [pqt_pkg::PORT_W-1:0]     out_found_port
);

  pqt_pkg::cmd_t cmd;
  pqt_pkg::sts_t sts;

  pqt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pqt_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_query_id       (in_query_id),
    .in_requester_ip   (in_requester_ip),
    .in_requester_port (in_requester_port),
    .out_status        (out_status),
    .out_slot_index    (out_slot_index),
    .out_found_ip      (out_found_ip),
    .out_found_port    (out_found_port)
  );

endmodule
